@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
        else $error("assertion failed");
`endif

@@ sv/hrhp_pkg.sv @@
// Package for the HTTP request head parser: types, codes and text tables.
// No dependencies.
package hrhp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_PROTO   = 3'd2,
        PH_MAJOR   = 3'd3,
        PH_MINOR   = 3'd4,
        PH_TAIL    = 3'd5,
        PH_HEADERS = 3'd6,
        PH_HALT    = 3'd7
    } t_phase;

    localparam logic [1:0] KIND_PATH    = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    localparam logic [1:0] VERD_OPTIONS   = 2'd0;
    localparam logic [1:0] VERD_NOT_ALLOW = 2'd1;
    localparam logic [1:0] VERD_TRAVERSAL = 2'd2;
    localparam logic [1:0] VERD_SERVE     = 2'd3;

    localparam logic [2:0] METH_GET     = 3'd0;
    localparam logic [2:0] METH_POST    = 3'd1;
    localparam logic [2:0] METH_HEAD    = 3'd2;
    localparam logic [2:0] METH_OPTIONS = 3'd3;
    localparam logic [2:0] METH_UNSUPP  = 3'd4;

    localparam logic [4:0] PREFIX_LEN  = 5'd17;
    localparam logic [4:0] PREFIX_DEAD = 5'd31;

    localparam int DATA_W = 32;
    localparam int USER_W = 2;

    typedef struct packed {
        logic [7:0] path_byte;
        logic [2:0] method;
        logic [7:0] ver_major;
        logic [7:0] ver_minor;
        logic [1:0] verdict;
        logic       gzip_ok;
        logic       deflate_ok;
    } t_payload;

    typedef struct packed {
        logic [1:0] kind;
        t_payload   pl;
    } t_result;

    // Pair of results a byte can produce (b is only used on a cut escape).
    typedef struct packed {
        logic    va;
        logic    vb;
        t_result a;
        t_result b;
    } t_res_pair;

    function automatic logic [7:0] meth_chr(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: case (p) 3'd0: c = "G"; 3'd1: c = "E"; 3'd2: c = "T"; default: c = 8'h00; endcase
            2'd1: case (p) 3'd0: c = "P"; 3'd1: c = "O"; 3'd2: c = "S"; 3'd3: c = "T";
                           default: c = 8'h00; endcase
            2'd2: case (p) 3'd0: c = "H"; 3'd1: c = "E"; 3'd2: c = "A"; 3'd3: c = "D";
                           default: c = 8'h00; endcase
            default: case (p)
                3'd0: c = "O"; 3'd1: c = "P"; 3'd2: c = "T"; 3'd3: c = "I";
                3'd4: c = "O"; 3'd5: c = "N"; 3'd6: c = "S"; default: c = 8'h00;
            endcase
        endcase
        return c;
    endfunction

    function automatic logic [2:0] meth_len(input logic [1:0] k);
        logic [2:0] l;
        case (k)
            2'd0: l = 3'd3;
            2'd1: l = 3'd4;
            2'd2: l = 3'd4;
            default: l = 3'd7;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] proto_chr(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "H"; 3'd1: c = "T"; 3'd2: c = "T"; 3'd3: c = "P"; 3'd4: c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] prefix_chr(input logic [4:0] i);
        logic [7:0] c;
        case (i)
            5'd0: c = "A"; 5'd1: c = "c"; 5'd2: c = "c"; 5'd3: c = "e"; 5'd4: c = "p";
            5'd5: c = "t"; 5'd6: c = "-"; 5'd7: c = "E"; 5'd8: c = "n"; 5'd9: c = "c";
            5'd10: c = "o"; 5'd11: c = "d"; 5'd12: c = "i"; 5'd13: c = "n"; 5'd14: c = "g";
            5'd15: c = ":"; 5'd16: c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] gz_chr(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "g"; 3'd1: c = "z"; 3'd2: c = "i"; 3'd3: c = "p";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] df_chr(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "d"; 3'd1: c = "e"; 3'd2: c = "f"; 3'd3: c = "l"; 3'd4: c = "a";
            3'd5: c = "t"; 3'd6: c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Hex digit value; bit 4 set when not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= "0" && c <= "9") v = {1'b0, c[3:0]};
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) v = {1'b0, c[3:0] + 4'd9};
        else v = 5'h10;
        return v;
    endfunction

endpackage

@@ sv/hrhp_core.sv @@
// Parser state and per-byte update: one byte in, up to two results out.
// Depends on hrhp_pkg.
module hrhp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_byte,
    input  logic                 i_conn_start,
    output hrhp_pkg::t_res_pair  o_res
);
    hrhp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_cand, n_cand;
    logic [2:0]  r_tlen, n_tlen;
    logic [1:0]  r_pct, n_pct;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_recent, n_recent;
    logic        r_query, n_query, r_trav, n_trav;
    logic [7:0]  r_major, n_major, r_minor, n_minor;
    logic [4:0]  r_pidx, n_pidx;
    logic [2:0]  r_gidx, n_gidx, r_didx, n_didx;
    logic [1:0]  r_enc, n_enc;
    logic [2:0]  r_lf, n_lf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrhp_pkg::PH_METHOD;
            r_cand <= 4'hF; r_tlen <= '0; r_pct <= '0; r_held <= '0; r_recent <= '0;
            r_query <= 1'b0; r_trav <= 1'b0; r_major <= '0; r_minor <= '0;
            r_pidx <= '0; r_gidx <= '0; r_didx <= '0; r_enc <= '0; r_lf <= 3'b001;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cand <= n_cand; r_tlen <= n_tlen; r_pct <= n_pct; r_held <= n_held;
            r_recent <= n_recent; r_query <= n_query; r_trav <= n_trav;
            r_major <= n_major; r_minor <= n_minor; r_pidx <= n_pidx;
            r_gidx <= n_gidx; r_didx <= n_didx; r_enc <= n_enc; r_lf <= n_lf;
        end
    end

    always_comb begin
        hrhp_pkg::t_phase ph;
        logic [3:0]  cand, keep;
        logic [2:0]  tlen, lf, mcode;
        logic [1:0]  pct, enc, vd;
        logic [7:0]  held, maj, mnr, b, dec;
        logic [15:0] recent;
        logic        qs, tr, is_end, fc, bad, emit_pct, emit_held, emit_one;
        logic [4:0]  pidx, h1, h2;
        logic [2:0]  gidx, didx;
        logic [7:0]  e0, e1;
        logic        v0, v1;
        hrhp_pkg::t_result ra, rb;

        b = i_byte;
        if (i_conn_start) begin
            ph = hrhp_pkg::PH_METHOD; cand = 4'hF; tlen = '0; pct = '0; held = '0;
            recent = '0; qs = 1'b0; tr = 1'b0; maj = '0; mnr = '0; pidx = '0;
            gidx = '0; didx = '0; enc = '0; lf = 3'b001;
        end else begin
            ph = r_phase; cand = r_cand; tlen = r_tlen; pct = r_pct; held = r_held;
            recent = r_recent; qs = r_query; tr = r_trav; maj = r_major; mnr = r_minor;
            pidx = r_pidx; gidx = r_gidx; didx = r_didx; enc = r_enc; lf = r_lf;
        end
        is_end = (b == 8'h0A) && lf[1];
        fc = lf[2] || (lf[0] && b == 8'h0D);
        bad = 1'b0;
        emit_pct = 1'b0; emit_held = 1'b0; emit_one = 1'b0; dec = b;
        h1 = hrhp_pkg::hex_val(held); h2 = hrhp_pkg::hex_val(b);
        keep = '0;
        mcode = hrhp_pkg::METH_UNSUPP; vd = hrhp_pkg::VERD_OPTIONS;
        ra = '0; rb = '0; v0 = 1'b0; v1 = 1'b0;
        e0 = 8'h00; e1 = 8'h00;

        case (ph)
            hrhp_pkg::PH_METHOD: begin
                if (is_end) bad = 1'b1;
                else if (b == " ") begin
                    for (int k = 0; k < 4; k++)
                        keep[k] = cand[k] && (hrhp_pkg::meth_len(2'(k)) == tlen);
                    cand = keep; tlen = '0; ph = hrhp_pkg::PH_PATH;
                end else begin
                    for (int k = 0; k < 4; k++)
                        if (!(tlen < hrhp_pkg::meth_len(2'(k)) &&
                              b == hrhp_pkg::meth_chr(2'(k), tlen)))
                            cand[k] = 1'b0;
                    tlen = (tlen < 3'd7) ? tlen + 3'd1 : 3'd7;
                end
            end
            hrhp_pkg::PH_PATH: begin
                if (is_end) bad = 1'b1;
                else if (b == " ") begin
                    emit_pct = (pct != 2'd0); emit_held = (pct == 2'd2);
                    pct = '0; tlen = '0; ph = hrhp_pkg::PH_PROTO;
                end else if (pct == 2'd0) begin
                    if (b == "%") pct = 2'd1; else emit_one = 1'b1;
                end else if (pct == 2'd1) begin
                    held = b; pct = 2'd2;
                end else begin
                    if (h1[4]) dec = 8'h00;
                    else if (h2[4]) dec = {4'h0, h1[3:0]};
                    else dec = {h1[3:0], h2[3:0]};
                    emit_one = 1'b1; pct = '0;
                end
            end
            hrhp_pkg::PH_PROTO: begin
                if (tlen < 3'd5 && b == hrhp_pkg::proto_chr(tlen)) begin
                    if (tlen == 3'd4) begin
                        tlen = '0; ph = hrhp_pkg::PH_MAJOR;
                    end else tlen = tlen + 3'd1;
                end else bad = 1'b1;
            end
            hrhp_pkg::PH_MAJOR: begin
                if (b >= "0" && b <= "9") maj = 8'((maj << 3) + (maj << 1) + {4'h0, b[3:0]});
                else if (b == ".") ph = hrhp_pkg::PH_MINOR;
                else bad = 1'b1;
            end
            hrhp_pkg::PH_MINOR: begin
                if (b >= "0" && b <= "9") mnr = 8'((mnr << 3) + (mnr << 1) + {4'h0, b[3:0]});
                else if (b == 8'h0D) ph = hrhp_pkg::PH_TAIL;
                else bad = 1'b1;
            end
            hrhp_pkg::PH_TAIL: begin
                if (is_end) ph = hrhp_pkg::PH_HEADERS;
            end
            hrhp_pkg::PH_HEADERS: begin
                if (pidx < hrhp_pkg::PREFIX_LEN) begin
                    pidx = (b == hrhp_pkg::prefix_chr(pidx)) ? pidx + 5'd1
                                                             : hrhp_pkg::PREFIX_DEAD;
                end else if (pidx == hrhp_pkg::PREFIX_LEN) begin
                    if (gidx < 3'd4 && b == hrhp_pkg::gz_chr(gidx)) begin
                        if (gidx == 3'd3) begin
                            enc[0] = 1'b1; gidx = '0;
                        end else gidx = gidx + 3'd1;
                    end else gidx = (b == "g") ? 3'd1 : 3'd0;
                    if (didx < 3'd7 && b == hrhp_pkg::df_chr(didx)) begin
                        if (didx == 3'd6) begin
                            enc[1] = 1'b1; didx = '0;
                        end else didx = didx + 3'd1;
                    end else didx = (b == "d") ? 3'd1 : 3'd0;
                end
                if (is_end) begin
                    pidx = '0; gidx = '0; didx = '0;
                    if (fc) begin
                        // first live candidate wins
                        if (cand[0]) mcode = hrhp_pkg::METH_GET;
                        else if (cand[1]) mcode = hrhp_pkg::METH_POST;
                        else if (cand[2]) mcode = hrhp_pkg::METH_HEAD;
                        else if (cand[3]) mcode = hrhp_pkg::METH_OPTIONS;
                        else mcode = hrhp_pkg::METH_UNSUPP;
                        if (mcode == hrhp_pkg::METH_OPTIONS) vd = hrhp_pkg::VERD_OPTIONS;
                        else if (mcode == hrhp_pkg::METH_UNSUPP) vd = hrhp_pkg::VERD_NOT_ALLOW;
                        else vd = tr ? hrhp_pkg::VERD_TRAVERSAL : hrhp_pkg::VERD_SERVE;
                        ra.kind = hrhp_pkg::KIND_VERDICT;
                        ra.pl.method = mcode; ra.pl.ver_major = maj; ra.pl.ver_minor = mnr;
                        ra.pl.verdict = vd; ra.pl.gzip_ok = enc[0]; ra.pl.deflate_ok = enc[1];
                        v0 = 1'b1;
                        ph = hrhp_pkg::PH_HALT;
                    end
                end
            end
            default: ;
        endcase

        // Path emission, at most two bytes in sequence through query/traversal tracking.
        if (emit_one) e0 = dec;
        else if (emit_pct) e0 = "%";
        e1 = held;
        if (emit_one || emit_pct) begin
            if (!qs) begin
                if (e0 == "?") qs = 1'b1;
                else begin
                    if (e0 == "." && recent == {8'h2F, 8'h2E}) tr = 1'b1;
                    recent = {recent[7:0], e0};
                    ra = '0; ra.pl.path_byte = e0; v0 = 1'b1;
                end
            end
        end
        if (emit_held && !qs) begin
            if (e1 == "?") qs = 1'b1;
            else begin
                if (e1 == "." && recent == {8'h2F, 8'h2E}) tr = 1'b1;
                recent = {recent[7:0], e1};
                rb = '0; rb.pl.path_byte = e1; v1 = 1'b1;
            end
        end
        if (bad) begin
            if (v0) begin
                rb = '0; rb.kind = hrhp_pkg::KIND_BAD; v1 = 1'b1;
            end else begin
                ra = '0; ra.kind = hrhp_pkg::KIND_BAD; v0 = 1'b1;
            end
            ph = hrhp_pkg::PH_HALT;
        end
        if (v1 && !v0) begin
            ra = rb; v0 = 1'b1; v1 = 1'b0;
        end

        if (is_end) lf = 3'b001;
        else lf = {fc, (b == 8'h0D), 1'b0};

        n_phase = ph; n_cand = cand; n_tlen = tlen; n_pct = pct; n_held = held;
        n_recent = recent; n_query = qs; n_trav = tr; n_major = maj; n_minor = mnr;
        n_pidx = pidx; n_gidx = gidx; n_didx = didx; n_enc = enc; n_lf = lf;
        o_res.va = v0; o_res.vb = v1; o_res.a = ra; o_res.b = rb;
    end
endmodule

@@ sv/hrhp_outq.sv @@
// Result register pair: holds up to two results of one byte and drains them in order.
// Depends on hrhp_pkg.
module hrhp_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  hrhp_pkg::t_res_pair  i_res,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic                 o_empty_next,
    output hrhp_pkg::t_result    o_res,
    output logic                 o_last
);
    logic r_v0, r_v1, n_v0, n_v1;
    hrhp_pkg::t_result r_a, r_b, n_a, n_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0; r_v1 <= n_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b;
    end

    // Can take a new byte when no result is left, or only the final one is left and it is taken now.
    assign o_empty_next = !r_v0 || (!r_v1 && i_ready);

    always_comb begin
        n_v0 = r_v0; n_v1 = r_v1; n_a = r_a; n_b = r_b;
        if (r_v0 && i_ready) begin
            n_v0 = r_v1; n_a = r_b; n_v1 = 1'b0;
        end
        if (i_load) begin
            n_v0 = i_res.va; n_v1 = i_res.vb; n_a = i_res.a; n_b = i_res.b;
        end
    end

    assign o_valid = r_v0;
    assign o_res = r_a;
    assign o_last = !r_v1;
endmodule

@@ sv/http_request_head_parser.sv @@
// One request byte is taken per cycle when the result side keeps up; the
// parser state updates in the same cycle and the byte's results land in a
// two-entry result register. A byte yields at most two results (only a cut
// percent escape at the path's end does); while two are pending, input stalls
// until the first is taken. A byte's first result is valid in the next cycle.
// Depends on hrhp_pkg, hrhp_core and hrhp_outq.
module http_request_head_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // rx_byte
    input  logic                        s_axis_tuser,  // conn_start
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [hrhp_pkg::DATA_W-1:0] m_axis_tdata,  // path_byte, method, ver_major,
                                                       // ver_minor, verdict, gzip_ok,
                                                       // deflate_ok, zero fill
    output logic [hrhp_pkg::USER_W-1:0] m_axis_tuser,  // kind
    output logic                        m_axis_tlast   // last
);
    hrhp_pkg::t_res_pair w_res;
    hrhp_pkg::t_result   w_out;
    logic w_acc, w_free;

    assign s_axis_tready = w_free;
    assign w_acc = s_axis_tvalid && w_free;

    hrhp_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_acc),
        .i_byte(s_axis_tdata), .i_conn_start(s_axis_tuser), .o_res(w_res)
    );

    hrhp_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_acc), .i_res(w_res),
        .i_ready(m_axis_tready), .o_valid(m_axis_tvalid), .o_empty_next(w_free),
        .o_res(w_out), .o_last(m_axis_tlast)
    );

    assign m_axis_tuser = w_out.kind;
    assign m_axis_tdata = {1'b0, w_out.pl.deflate_ok, w_out.pl.gzip_ok, w_out.pl.verdict,
                           w_out.pl.ver_minor, w_out.pl.ver_major, w_out.pl.method,
                           w_out.pl.path_byte};
endmodule

@@ sv/hrhp_checker.sv @@
// Port-level checker for the request head parser, bound to the top level.
// Depends on assert_macros.svh and hrhp_pkg.
`include "assert_macros.svh"
module hrhp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [hrhp_pkg::DATA_W-1:0] m_axis_tdata,
    input logic [hrhp_pkg::USER_W-1:0] m_axis_tuser,
    input logic                        m_axis_tlast
)
;
    // a stalled item holds still until taken
    `ASSERT_IMPL(a_hold_stalled, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    `ASSERT_IMPL(a_bad_last, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser == hrhp_pkg::KIND_BAD) |-> m_axis_tlast)
    `ASSERT_IMPL(a_verdict_last, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser == hrhp_pkg::KIND_VERDICT) |-> m_axis_tlast)
    `ASSERT_IMPL(a_ready_when_idle, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
    `ASSERT_IMPL(a_path_fields, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser == hrhp_pkg::KIND_PATH) |-> m_axis_tdata[31:8] == 24'h0)
endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

@@ tb/tb_top.sv @@
// Self-checking bench for http_request_head_parser: request bytes in, path bytes,
// verdicts and malformed-line results out, checked against an in-bench parser model.
// Depends on hrhp_pkg and the parser RTL.
module tb_top;

    localparam logic [7:0] CR = 8'h0D;
    localparam logic [7:0] LF = 8'h0A;
    localparam logic [7:0] SP = 8'h20;
    localparam logic [4:0] HDR_DEAD = 5'd31;

    typedef struct {
        logic [7:0] b;
        logic       cs;
    } t_rx_item;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] pb;
        logic [2:0] meth;
        logic [7:0] maj;
        logic [7:0] mnr;
        logic [1:0] verd;
        logic       gz;
        logic       df;
        logic       last;
    } t_head_res;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [7:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [hrhp_pkg::DATA_W-1:0] m_axis_tdata;
    logic [hrhp_pkg::USER_W-1:0] m_axis_tuser;

    http_request_head_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    t_rx_item  rx_pending[$];
    t_head_res head_expected[$];
    int errors = 0, bytes_sent = 0, path_seen = 0, verdicts_seen = 0, bad_seen = 0;
    int results_seen = 0;
    int start_mark = 0;

    string meth_txt[4] = '{"GET", "POST", "HEAD", "OPTIONS"};
    string proto_txt = "HTTP/";
    string hdr_txt = "Accept-Encoding: ";
    string gz_txt = "gzip";
    string df_txt = "deflate";

    // parser model state
    hrhp_pkg::t_phase ph;
    logic [3:0] cand;
    logic [2:0] tlen;
    logic [1:0] pcnt;
    logic [7:0] pheld;
    logic [15:0] recent;
    logic       qseen, trav;
    logic [7:0] maj_acc, mnr_acc;
    logic [4:0] hidx;
    logic [2:0] gidx, didx;
    logic [1:0] enc;
    logic [2:0] lflags;   // bit0 line start, bit1 previous CR, bit2 first byte CR

    function automatic void clear_parser();
        ph = hrhp_pkg::PH_METHOD; cand = 4'hF; tlen = 0; pcnt = 0; pheld = 0; recent = 0;
        qseen = 0; trav = 0; maj_acc = 0; mnr_acc = 0; hidx = 0; gidx = 0; didx = 0;
        enc = 0; lflags = 3'b001;
    endfunction

    function automatic void push_res(logic [1:0] kind, logic [7:0] pb, logic [2:0] meth,
                                     logic [1:0] verd);
        t_head_res r;
        r.kind = kind; r.pb = pb; r.meth = meth; r.verd = verd; r.last = 0;
        r.maj = (kind == hrhp_pkg::KIND_VERDICT) ? maj_acc : 8'd0;
        r.mnr = (kind == hrhp_pkg::KIND_VERDICT) ? mnr_acc : 8'd0;
        r.gz = (kind == hrhp_pkg::KIND_VERDICT) ? enc[0] : 1'b0;
        r.df = (kind == hrhp_pkg::KIND_VERDICT) ? enc[1] : 1'b0;
        head_expected.push_back(r);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic void emit_path(logic [7:0] d);
        if (qseen) return;
        if (d == "?") begin
            qseen = 1;
            return;
        end
        if (d == "." && recent[7:0] == "." && recent[15:8] == "/") trav = 1;
        recent = {recent[7:0], d};
        push_res(hrhp_pkg::KIND_PATH, d, 3'd0, 2'd0);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic cs);
        bit is_end, fc, bad;
        int n0, pos, h1, h2, m;
        logic [3:0] keep;
        logic [1:0] v;
        bad = 0;
        if (cs) clear_parser();
        n0 = head_expected.size();
        is_end = (b == LF) && lflags[1];
        fc = lflags[2] || (lflags[0] && b == CR);
        case (ph)
            hrhp_pkg::PH_METHOD: begin
                if (is_end) bad = 1;
                else if (b == SP) begin
                    keep = 0;
                    for (int k = 0; k < 4; k++)
                        if (cand[k] && meth_txt[k].len() == tlen) keep[k] = 1;
                    cand = keep; tlen = 0; ph = hrhp_pkg::PH_PATH;
                end else begin
                    pos = tlen;
                    for (int k = 0; k < 4; k++)
                        if (!(pos < meth_txt[k].len() && b == meth_txt[k][pos])) cand[k] = 0;
                    tlen = 3'((pos < 7) ? pos + 1 : 7);
                end
            end
            hrhp_pkg::PH_PATH: begin
                if (is_end) bad = 1;
                else if (b == SP) begin
                    // escape cut short by the space: emit it literally
                    if (pcnt >= 1) emit_path("%");
                    if (pcnt == 2) emit_path(pheld);
                    pcnt = 0; tlen = 0; ph = hrhp_pkg::PH_PROTO;
                end else if (pcnt == 0) begin
                    if (b == "%") pcnt = 1;
                    else emit_path(b);
                end else if (pcnt == 1) begin
                    pheld = b; pcnt = 2;
                end else begin
                    h1 = hex_digit(pheld); h2 = hex_digit(b);
                    if (h1 > 15) emit_path(8'd0);
                    else if (h2 > 15) emit_path(8'(h1));
                    else emit_path(8'(h1 * 16 + h2));
                    pcnt = 0;
                end
            end
            hrhp_pkg::PH_PROTO: begin
                if (tlen < 5 && b == proto_txt[tlen]) begin
                    tlen++;
                    if (tlen == 5) begin
                        tlen = 0; ph = hrhp_pkg::PH_MAJOR;
                    end
                end else bad = 1;
            end
            hrhp_pkg::PH_MAJOR: begin
                if (b >= "0" && b <= "9") maj_acc = 8'(maj_acc * 10 + (b - "0"));
                else if (b == ".") ph = hrhp_pkg::PH_MINOR;
                else bad = 1;
            end
            hrhp_pkg::PH_MINOR: begin
                if (b >= "0" && b <= "9") mnr_acc = 8'(mnr_acc * 10 + (b - "0"));
                else if (b == CR) ph = hrhp_pkg::PH_TAIL;
                else bad = 1;
            end
            hrhp_pkg::PH_TAIL: begin
                if (is_end) ph = hrhp_pkg::PH_HEADERS;
            end
            hrhp_pkg::PH_HEADERS: begin
                if (hidx < hrhp_pkg::PREFIX_LEN) begin
                    hidx = (b == hdr_txt[hidx]) ? 5'(hidx + 1) : HDR_DEAD;
                end else if (hidx == hrhp_pkg::PREFIX_LEN) begin
                    if (gidx < 4 && b == gz_txt[gidx]) begin
                        gidx++;
                        if (gidx == 4) begin
                            enc[0] = 1; gidx = 0;
                        end
                    end else gidx = (b == "g") ? 3'd1 : 3'd0;
                    if (didx < 7 && b == df_txt[didx]) begin
                        didx++;
                        if (didx == 7) begin
                            enc[1] = 1; didx = 0;
                        end
                    end else didx = (b == "d") ? 3'd1 : 3'd0;
                end
                if (is_end) begin
                    hidx = 0; gidx = 0; didx = 0;
                    if (fc) begin
                        m = hrhp_pkg::METH_UNSUPP;
                        for (int k = 3; k >= 0; k--) if (cand[k]) m = k;
                        if (m == hrhp_pkg::METH_OPTIONS) v = hrhp_pkg::VERD_OPTIONS;
                        else if (m == hrhp_pkg::METH_UNSUPP) v = hrhp_pkg::VERD_NOT_ALLOW;
                        else v = trav ? hrhp_pkg::VERD_TRAVERSAL : hrhp_pkg::VERD_SERVE;
                        push_res(hrhp_pkg::KIND_VERDICT, 8'd0, 3'(m), v);
                        ph = hrhp_pkg::PH_HALT;
                    end
                end
            end
            default: ;
        endcase
        if (bad) begin
            push_res(hrhp_pkg::KIND_BAD, 8'd0, 3'd0, 2'd0);
            ph = hrhp_pkg::PH_HALT;
        end
        if (is_end) lflags = 3'b001;
        else lflags = {fc, b == CR, 1'b0};
        if (head_expected.size() > n0) head_expected[head_expected.size() - 1].last = 1;
    endfunction

    // ---------------- stimulus helpers
    function automatic void add_byte(logic [7:0] b, logic cs = 0);
        t_rx_item it;
        it.b = b; it.cs = cs;
        rx_pending.push_back(it);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic logic [7:0] hex_char();
        string hx = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return hx[$urandom_range(0, hx.len() - 1)];
    endfunction

    function automatic void add_request();
        string lit = "az./-_";
        string words[6] = '{"gzip", "deflate", "gzgzip", "deflat", ", ", "br"};
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            // noise burst: the first byte carries the start flag, the others a random one
            add_byte(8'($urandom_range(0, 255)), 1);
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)), 1'($urandom));
            return;
        end
        sel = $urandom_range(0, 11);
        if (sel < 8) add_text(meth_txt[sel % 4]);
        else if (sel == 8) add_text("OPTIONSX");
        else if (sel == 9) add_text("GE");
        else if (sel == 10) repeat ($urandom_range(1, 9)) add_byte(8'($urandom_range(65, 90)));
        else begin
            add_text("GET\r\n");
            rx_pending[rx_pending.size() - 5].cs = 1;
            return;
        end
        // the request's first byte carries the start flag
        rx_pending[start_mark].cs = 1;
        add_text(" /");
        repeat ($urandom_range(0, 6)) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) add_byte(lit[$urandom_range(0, lit.len() - 1)]);
            else if (sel < 5) begin
                add_byte("%"); add_byte(hex_char()); add_byte(hex_char());
            end else if (sel == 5) add_text("/..");
            else if (sel == 6) add_text("/%2e%2E");
            else if (sel == 7) add_byte("?");
            else if (sel == 8) add_byte(8'($urandom_range(0, 255)));
            else add_text("\r\n");
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) add_byte("%");
        else if (sel == 1) begin
            add_byte("%"); add_byte(hex_char());
        end
        add_byte(SP);
        add_text(proto_txt);
        if ($urandom_range(0, 11) == 0) rx_pending[rx_pending.size() - 1 -
            $urandom_range(0, 4)].b = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 4)) add_byte(8'("0" + $urandom_range(0, 9)));
        add_byte(".");
        repeat ($urandom_range(0, 4)) add_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 11) == 0) add_byte(8'($urandom_range(0, 255)));
        add_byte(CR);
        if ($urandom_range(0, 3) == 0) add_text("x\r");
        add_byte(LF);
        repeat ($urandom_range(0, 3)) begin
            sel = $urandom_range(0, 5);
            if (sel < 3) begin
                add_text(hdr_txt);
                repeat ($urandom_range(1, 3)) add_text(words[$urandom_range(0, 5)]);
            end else if (sel == 3) add_text("Accept-Encodinx: gzip");
            else if (sel == 4) add_text("Host: a\rb\nc");
            else add_byte(CR);
            add_text("\r\n");
        end
        add_text("\r\n");
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- clock, reset, limit
    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;
    end

    initial begin
        #3000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // ---------------- driver
    logic taken;
    int   tx_gap;
    bit   calm_tx;

    always @(posedge i_clk) begin
        taken <= 0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            parse_byte(s_axis_tdata, s_axis_tuser);
            bytes_sent++;
            taken <= 1;
        end
    end

    initial begin
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        tx_gap = 0; calm_tx = 0; taken = 0;
    end

    always @(negedge i_clk) begin
        t_rx_item it;
        if (i_rst_n && (!s_axis_tvalid || taken)) begin
            if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 0;
            end else if (rx_pending.size() > 0) begin
                it = rx_pending.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tdata <= it.b;
                s_axis_tuser <= it.cs;
                tx_gap = calm_tx ? 0 : gap_len();
            end else s_axis_tvalid <= 0;
        end
    end

    // ---------------- receiver and checker
    int hold_cycles = 0;
    bit hold_done = 0;
    bit calm_rx = 0;

    initial m_axis_tready = 0;

    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
        if (!hold_done && results_seen >= 60) begin
            hold_done = 1;
            hold_cycles = 300;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 0;
        end else if (calm_rx) m_axis_tready <= 1;
        else if ($urandom_range(0, 99) < 8) begin
            hold_cycles = $urandom_range(1, 25);
            m_axis_tready <= 0;
        end else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_head_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (head_expected.size() == 0) begin
                $error("result with nothing expected (kind %0d)", m_axis_tuser);
                errors++;
            end else begin
                e = head_expected.pop_front();
                check_field("kind", e.kind, m_axis_tuser);
                check_field("path_byte", e.pb, m_axis_tdata[7:0]);
                check_field("method", e.meth, m_axis_tdata[10:8]);
                check_field("ver_major", e.maj, m_axis_tdata[18:11]);
                check_field("ver_minor", e.mnr, m_axis_tdata[26:19]);
                check_field("verdict", e.verd, m_axis_tdata[28:27]);
                check_field("gzip_ok", e.gz, m_axis_tdata[29]);
                check_field("deflate_ok", e.df, m_axis_tdata[30]);
                check_field("last", e.last, m_axis_tlast);
                case (e.kind)
                    hrhp_pkg::KIND_PATH: path_seen++;
                    hrhp_pkg::KIND_VERDICT: verdicts_seen++;
                    default: bad_seen++;
                endcase
            end
        end
    end

    // ---------------- test sequence
    initial begin
        int n;
        clear_parser();
        // cut escape, version wrap, options
        start_mark = rx_pending.size();
        add_byte("O", 1); add_text("PTIONS /%4 HTTP/300.0\r\n\r\n");
        // traversal through escapes, both encodings, query cut
        add_byte("G", 1); add_text("ET /%2e%2E?%zz HTTP/1.1\r\nAccept-Encoding: gzip,deflate\r\n\r\n");
        // early line end and ordinary control bytes
        add_byte(8'h00, 1); add_text("\n\r\r\n");
        add_byte("P", 1); add_text("OST /a%4g%ff%z1\r\n");
        add_byte(8'hFF, 1);
        // sender pause: wait until every result of the directed part is back
        while (rx_pending.size() > 0 || s_axis_tvalid || head_expected.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        n = 0;
        while (n < 290) begin
            start_mark = rx_pending.size();
            add_request();
            n = rx_pending.size();
        end
        while (rx_pending.size() > 0 || s_axis_tvalid || head_expected.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (head_expected.size() > 0) begin
            $error("%0d results never arrived", head_expected.size());
            errors++;
        end
        $display("Sent %0d request bytes; checked %0d path bytes, %0d verdicts, %0d malformed.",
                 bytes_sent, path_seen, verdicts_seen, bad_seen);
        if (errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end
endmodule
